/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BFDH_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bloom filter check failed");

// property checked on every rising edge, reset included
`define BFDH_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("bloom filter reset check failed");

`endif

/* design/bfdh_pkg.sv */
// ----------------------------------------------------------------------------
// bfdh_pkg
// shared types and constants of the bloom filter double hash unit
// ----------------------------------------------------------------------------
`default_nettype none

package bfdh_pkg;

    localparam int WORD_BITS   = 64;
    localparam int MAX_WORDS   = 1024;
    localparam int FILTER_BITS = WORD_BITS * MAX_WORDS;

    localparam int WORD_IDX_W  = $clog2(MAX_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int POS_W       = WORD_IDX_W + BIT_IDX_W;

    localparam int HASH_W      = 32;
    localparam int WIDTH_W     = 17;
    localparam int NHASH_W     = 6;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;

    // remainder unit: hash bits consumed per cycle
    localparam int DIGIT_BITS  = 4;
    localparam int MOD_STEPS   = HASH_W / DIGIT_BITS;
    localparam int STEP_CNT_W  = $clog2(MOD_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 2'd1;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(FILTER_BITS);
    localparam logic [NHASH_W-1:0] NHASH_RESET = NHASH_W'(4);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic check;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic n_zero;
        logic mod_last;
        logic probe_last;
        logic bit_set;
        logic is_test;
    } t_dp_stat;

    // one restoring remainder step: bring in one dividend bit
    function automatic logic [POS_W-1:0] rem_step(
        input logic [POS_W-1:0]   rem,
        input logic               din,
        input logic [WIDTH_W-1:0] modulus
    );
        logic [WIDTH_W-1:0] t;
        t = {rem, din};
        if (t >= modulus) begin
            t = t - modulus;
        end
        return t[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/bfdh_ram.sv */
// ----------------------------------------------------------------------------
// bfdh_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/bfdh_datapath.sv */
// ----------------------------------------------------------------------------
// bfdh_datapath
// config registers, probe position arithmetic, remainder unit and bit store
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bfdh_pkg::t_dp_cmd                  i_cmd,
    output bfdh_pkg::t_dp_stat                      o_stat,
    input  wire logic                               i_func,
    input  wire logic [bfdh_pkg::HASH_W-1:0]        i_key_hash_a,
    input  wire logic [bfdh_pkg::HASH_W-1:0]        i_key_hash_b,
    input  wire logic                               i_cfg_we,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                    o_present
);

    logic [bfdh_pkg::WIDTH_W-1:0]    r_width_bits;
    logic [bfdh_pkg::NHASH_W-1:0]    r_num_hashes;
    logic                            r_func;
    logic                            r_present;
    logic [bfdh_pkg::HASH_W-1:0]     r_hb;
    logic [bfdh_pkg::HASH_W-1:0]     r_sum;
    logic [bfdh_pkg::HASH_W-1:0]     r_div;
    logic [bfdh_pkg::POS_W-1:0]      r_rem;
    logic [bfdh_pkg::POS_W-1:0]      n_rem;
    logic [bfdh_pkg::STEP_CNT_W-1:0] r_step_cnt;
    logic [bfdh_pkg::NHASH_W-1:0]    r_probe_cnt;
    logic [bfdh_pkg::WORD_IDX_W-1:0] r_clr_addr;
    logic [bfdh_pkg::WIDTH_W-1:0]    w_eff;
    logic [bfdh_pkg::HASH_W-1:0]     next_sum;
    logic [bfdh_pkg::WORD_IDX_W-1:0] word_idx;
    logic [bfdh_pkg::BIT_IDX_W-1:0]  bit_idx;
    logic [bfdh_pkg::WORD_BITS-1:0]  rd_data;
    logic [bfdh_pkg::WORD_BITS-1:0]  onehot;
    logic                            ram_we;
    logic [bfdh_pkg::WORD_IDX_W-1:0] ram_waddr;
    logic [bfdh_pkg::WORD_BITS-1:0]  ram_wdata;

    // width zero acts as one, width above the store saturates
    always_comb begin
        if (r_width_bits == '0) begin
            w_eff = bfdh_pkg::WIDTH_W'(1);
        end else if (r_width_bits > bfdh_pkg::WIDTH_W'(bfdh_pkg::FILTER_BITS)) begin
            w_eff = bfdh_pkg::WIDTH_W'(bfdh_pkg::FILTER_BITS);
        end else begin
            w_eff = r_width_bits;
        end
    end

    always_comb begin
        n_rem = r_rem;
        for (int k = 0; k < bfdh_pkg::DIGIT_BITS; k++) begin
            n_rem = bfdh_pkg::rem_step(n_rem, r_div[bfdh_pkg::HASH_W-1-k], w_eff);
        end
    end

    assign next_sum = r_sum + r_hb;
    assign word_idx = r_rem[bfdh_pkg::POS_W-1:bfdh_pkg::BIT_IDX_W];
    assign bit_idx  = r_rem[bfdh_pkg::BIT_IDX_W-1:0];
    assign onehot   = bfdh_pkg::WORD_BITS'(1) << bit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_bits <= bfdh_pkg::WIDTH_RESET;
            r_num_hashes <= bfdh_pkg::NHASH_RESET;
            r_clr_addr   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bfdh_pkg::CFG_WIDTH_BITS: r_width_bits <= i_cfg_data;
                    bfdh_pkg::CFG_NUM_HASHES:
                        r_num_hashes <= i_cfg_data[bfdh_pkg::NHASH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_present   <= (i_func == bfdh_pkg::FUNC_TEST);
            r_hb        <= i_key_hash_b;
            r_sum       <= i_key_hash_a;
            r_div       <= i_key_hash_a;
            r_rem       <= '0;
            r_step_cnt  <= '0;
            r_probe_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem      <= n_rem;
            r_div      <= r_div << bfdh_pkg::DIGIT_BITS;
            r_step_cnt <= r_step_cnt + 1'b1;
        end else if (i_cmd.check) begin
            if (r_func == bfdh_pkg::FUNC_TEST && !rd_data[bit_idx]) begin
                r_present <= 1'b0;
            end
            // set up the next probe
            r_sum       <= next_sum;
            r_div       <= next_sum;
            r_rem       <= '0;
            r_step_cnt  <= '0;
            r_probe_cnt <= r_probe_cnt + 1'b1;
        end
    end

    assign ram_we    = i_cmd.clr_step || (i_cmd.check && r_func == bfdh_pkg::FUNC_ADD);
    assign ram_waddr = i_cmd.clr_step ? r_clr_addr : word_idx;
    assign ram_wdata = i_cmd.clr_step ? '0 : (rd_data | onehot);

    bfdh_ram #(
        .WIDTH (bfdh_pkg::WORD_BITS),
        .DEPTH (bfdh_pkg::MAX_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (word_idx),
        .o_rdata (rd_data)
    );

    assign o_stat.clr_last   = &r_clr_addr;
    assign o_stat.n_zero     = (r_num_hashes == '0);
    assign o_stat.mod_last   = (r_step_cnt == bfdh_pkg::STEP_CNT_W'(bfdh_pkg::MOD_STEPS - 1));
    assign o_stat.probe_last = ({1'b0, r_probe_cnt} + 1'b1 == {1'b0, r_num_hashes});
    assign o_stat.bit_set    = rd_data[bit_idx];
    assign o_stat.is_test    = (r_func == bfdh_pkg::FUNC_TEST);
    assign o_present         = r_present;

endmodule

`default_nettype wire

/* design/bfdh_ctrl.sv */
// ----------------------------------------------------------------------------
// bfdh_ctrl
// sequencer for store clearing and the probe loop of each request
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire bfdh_pkg::t_dp_stat i_stat,
    output bfdh_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy,
    output logic                    o_done
);

    bfdh_pkg::t_state r_state;
    bfdh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfdh_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfdh_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) n_state = bfdh_pkg::ST_IDLE;
            end
            bfdh_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = i_stat.n_zero ? bfdh_pkg::ST_DONE : bfdh_pkg::ST_MOD;
                end
            end
            bfdh_pkg::ST_MOD: begin
                if (i_stat.mod_last) n_state = bfdh_pkg::ST_READ;
            end
            bfdh_pkg::ST_READ: begin
                n_state = bfdh_pkg::ST_CHECK;
            end
            bfdh_pkg::ST_CHECK: begin
                // a test stops at the first clear bit
                if (i_stat.probe_last || (i_stat.is_test && !i_stat.bit_set)) begin
                    n_state = bfdh_pkg::ST_DONE;
                end else begin
                    n_state = bfdh_pkg::ST_MOD;
                end
            end
            bfdh_pkg::ST_DONE: begin
                n_state = bfdh_pkg::ST_IDLE;
            end
            default: n_state = bfdh_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            bfdh_pkg::ST_CLEAR: o_cmd.clr_step = 1'b1;
            bfdh_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            bfdh_pkg::ST_MOD:   o_cmd.mod_step = 1'b1;
            bfdh_pkg::ST_READ:  ;
            bfdh_pkg::ST_CHECK: o_cmd.check = 1'b1;
            bfdh_pkg::ST_DONE:  o_done = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* design/bloom_filter_double_hash_unit.sv */
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_unit
// bloom filter bit store probed by double hashing, add and test requests
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// request   in         start && !busy         i_func, i_key_hash_a, i_key_hash_b
// result    out        o_done (one cycle)     o_present
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// sequence: each probe runs 8 remainder steps at 4 hash bits per cycle,
//   then one ram read and one check/write; a test stops at the first clear
//   bit, and num_hashes zero goes straight to the result strobe
// the rate is set by the shared remainder unit and the single ram port pair
// reset: after reset the 1024-word store is cleared one word a cycle, with
//   busy high until the last word; config writes are taken meanwhile
// the result strobe cannot be stalled; it is raised for one cycle per request
//
`default_nettype none

module bloom_filter_double_hash_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_func,
    input  wire logic [bfdh_pkg::HASH_W-1:0]      i_key_hash_a,
    input  wire logic [bfdh_pkg::HASH_W-1:0]      i_key_hash_b,
    output logic                                  o_done,
    output logic                                  o_present,
    input  wire logic                             i_cfg_we,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    bfdh_pkg::t_dp_cmd  cmd;
    bfdh_pkg::t_dp_stat stat;
    logic               present_q;

    // sequencer: clearing pass, then one probe at a time per request
    bfdh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // position arithmetic, remainder unit and the bit store itself
    bfdh_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_key_hash_a (i_key_hash_a),
        .i_key_hash_b (i_key_hash_b),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_present    (present_q)
    );

    // present only shown alongside its strobe
    assign o_present = o_done && present_q;

endmodule

`default_nettype wire

/* design/bfdh_checker.sv */
// ----------------------------------------------------------------------------
// bfdh_checker
// port level checks of the bloom filter double hash unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bfdh_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             o_done,
    input wire logic                             o_present
);

    // an accepted request makes the unit busy in the cycle after it
    `BFDH_ASSERT(a_accept_busy, start && !busy |=> busy)
    // a result only appears while the unit is busy with it
    `BFDH_ASSERT(a_done_busy, o_done |-> busy)
    // the result strobe lasts exactly one cycle and frees the unit
    `BFDH_ASSERT(a_done_pulse, o_done |=> !o_done && !busy)
    // present is quiet outside a result
    `BFDH_ASSERT(a_present_quiet, !o_done |-> !o_present)
    // the clearing pass follows reset
    `BFDH_ASSERT_RST(a_reset_clear, !i_rst_n |=> busy && !o_done)

endmodule

bind bloom_filter_double_hash_unit bfdh_checker u_bfdh_checker (.*);

`default_nettype wire
